/* rtl/fhc_pkg.sv */
// Shared constants and result codes for the format header and CRC checker.
package fhc_pkg;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [31:0] MagicWord = 32'h004B_5259;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegCrcEnable   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStrictVer   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegExpMajor    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegExpMinor    = 2'd3;

  localparam int unsigned CountW = 4;
  localparam logic [CountW-1:0] CountSat = 4'd8;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusTruncated = 3'd1,
    StatusBadMagic  = 3'd2,
    StatusBadVer    = 3'd3,
    StatusCrcFail   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SevOk      = 2'd0,
    SevWarning = 2'd1,
    SevError   = 2'd2,
    SevFatal   = 2'd3
  } severity_e;

endpackage

/* rtl/fhc_crc_byte.sv */
// One byte of a reflected CRC-32 update.
module fhc_crc_byte
  import fhc_pkg::*;
(
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

/* rtl/format_header_and_crc_checker.sv */
// Top level of the format header and CRC trailer checker.
//
// The checker takes one byte of a serialized buffer per input transfer, from
// offset zero, with last_byte_i marking the final byte. It verifies the
// little-endian magic word at offsets 0 to 3, the major and minor version at
// offsets 4 and 5, and a reflected CRC-32 over all bytes but the last four,
// compared against the four trailing bytes taken as a little-endian word.
// Exactly one result transfer follows each final byte; other bytes give none.
// Throughput is one byte per clock cycle: the per-byte state update, including
// a full byte-wide CRC step, is combinational, and the verdict for a
// buffer is loaded into an output register at the same clock edge that
// accepts its final byte, so it is offered on the result channel from the
// next cycle on. A new byte is accepted whenever the output register is empty
// or is being drained in the same cycle, so a stalled result only holds off
// input while it waits. Configuration registers are written through a simple
// write-enable port and should only change while no buffer is in flight.
module format_header_and_crc_checker
  import fhc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  // Input byte channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,

  // Result channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_code_o,
  output logic [1:0]          severity_o,
  output logic                version_warning_o,
  output logic [31:0]         computed_crc_o
);

  // Configuration registers.
  logic       crc_en_q;
  logic       strict_q;
  logic [7:0] exp_major_q;
  logic [7:0] exp_minor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q    <= 1'b1;
      strict_q    <= 1'b0;
      exp_major_q <= 8'd1;
      exp_minor_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegCrcEnable: crc_en_q    <= cfg_wdata_i[0];
        RegStrictVer: strict_q    <= cfg_wdata_i[0];
        RegExpMajor:  exp_major_q <= cfg_wdata_i;
        RegExpMinor:  exp_minor_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Per-buffer state.
  logic [CountW-1:0] count_q, count_d;
  logic              magic_ok_q, magic_ok_d;
  logic [7:0]        major_q, major_d;
  logic [7:0]        minor_q, minor_d;
  logic [31:0]       crc_q, crc_d;
  logic [7:0]        trail_q [4];
  logic [7:0]        trail_d [4];

  // Output register.
  logic        out_valid_q;
  status_e     status_q, status_d;
  severity_e   sev_q, sev_d;
  logic        warn_q, warn_d;
  logic [31:0] crc_out_q, crc_out_d;

  logic in_xfer;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // The CRC runs one byte behind the four-byte trailer window, so bytes only
  // enter it once they can no longer be part of the trailer.
  logic [31:0] crc_step;
  fhc_crc_byte u_crc_byte (
    .crc_i  (crc_q),
    .byte_i (trail_q[0]),
    .crc_o  (crc_step)
  );

  logic [7:0] magic_want;
  always_comb begin
    case (count_q[1:0])
      2'd0:    magic_want = MagicWord[7:0];
      2'd1:    magic_want = MagicWord[15:8];
      2'd2:    magic_want = MagicWord[23:16];
      default: magic_want = MagicWord[31:24];
    endcase
  end

  // Updated state including the byte being accepted.
  logic        pos_hdr;
  logic [31:0] crc_inv;
  logic [31:0] stored;
  always_comb begin
    pos_hdr    = (count_q < CountW'(4));
    magic_ok_d = magic_ok_q && (!pos_hdr || (data_byte_i == magic_want));
    major_d    = (count_q == CountW'(4)) ? data_byte_i : major_q;
    minor_d    = (count_q == CountW'(5)) ? data_byte_i : minor_q;
    crc_d      = pos_hdr ? crc_q : crc_step;
    trail_d[0] = trail_q[1];
    trail_d[1] = trail_q[2];
    trail_d[2] = trail_q[3];
    trail_d[3] = data_byte_i;
    count_d    = (count_q < CountSat) ? count_q + CountW'(1) : count_q;
  end

  // Verdict for a final byte. The first failing check decides the status;
  // a newer major version in relaxed mode only flags a warning.
  always_comb begin
    crc_inv   = ~crc_d;
    stored    = {trail_d[3], trail_d[2], trail_d[1], trail_d[0]};
    status_d  = StatusOk;
    sev_d     = SevOk;
    warn_d    = 1'b0;
    crc_out_d = crc_inv;
    if (count_d < CountW'(4)) begin
      status_d = StatusTruncated;
      sev_d    = SevFatal;
    end else if (!magic_ok_d) begin
      status_d = StatusBadMagic;
      sev_d    = SevFatal;
    end else if (count_d < CountW'(6)) begin
      status_d = StatusTruncated;
      sev_d    = SevFatal;
    end else if (strict_q && (major_d != exp_major_q || minor_d != exp_minor_q)) begin
      status_d = StatusBadVer;
      sev_d    = SevError;
    end else begin
      if (!strict_q && (major_d > exp_major_q)) begin
        warn_d = 1'b1;
        sev_d  = SevWarning;
      end
      if (count_d < CountW'(8)) begin
        status_d = StatusTruncated;
        sev_d    = SevFatal;
      end else if (crc_en_q && (stored != crc_inv)) begin
        status_d = StatusCrcFail;
        sev_d    = SevError;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      magic_ok_q <= 1'b1;
      major_q    <= '0;
      minor_q    <= '0;
      crc_q      <= CrcInit;
      for (int i = 0; i < 4; i++) begin
        trail_q[i] <= '0;
      end
    end else if (in_xfer) begin
      if (last_byte_i) begin
        // The buffer is complete: return to the start-of-buffer state.
        count_q    <= '0;
        magic_ok_q <= 1'b1;
        major_q    <= '0;
        minor_q    <= '0;
        crc_q      <= CrcInit;
        for (int i = 0; i < 4; i++) begin
          trail_q[i] <= '0;
        end
      end else begin
        count_q    <= count_d;
        magic_ok_q <= magic_ok_d;
        major_q    <= major_d;
        minor_q    <= minor_d;
        crc_q      <= crc_d;
        for (int i = 0; i < 4; i++) begin
          trail_q[i] <= trail_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_byte_i) begin
      status_q  <= status_d;
      sev_q     <= sev_d;
      warn_q    <= warn_d;
      crc_out_q <= crc_out_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_code_o     = status_q;
  assign severity_o        = sev_q;
  assign version_warning_o = warn_q;
  assign computed_crc_o    = crc_out_q;

endmodule

/* tb/format_header_and_crc_checker_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the format header and CRC trailer checker.
module format_header_and_crc_checker_tb;
  import fhc_pkg::*;

  // The run is stopped here even if the block hangs. The limit leaves a wide
  // margin over a correct run for stalls on both sides.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReported = 10;

  // One verdict as the result channel carries it.
  typedef struct packed {
    status_e     status;
    severity_e   sev;
    logic        warn;
    logic [31:0] crc;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          status_code_o;
  logic [1:0]          severity_o;
  logic                version_warning_o;
  logic [31:0]         computed_crc_o;

  format_header_and_crc_checker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_code_o     (status_code_o),
    .severity_o        (severity_o),
    .version_warning_o (version_warning_o),
    .computed_crc_o    (computed_crc_o)
  );

  // Verdicts still owed by the block, oldest first.
  verdict_t verdict_q[$];
  // The buffer that the next call to send_frame streams out.
  logic [7:0] frame_q[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  // While set, neither side idles, so bytes and results move every cycle.
  bit burst_mode = 1'b0;

  // Our copy of the configuration registers, at their reset values.
  logic       crc_on_cfg = 1'b1;
  logic       strict_cfg = 1'b0;
  logic [7:0] exp_major_cfg = 8'd1;
  logic [7:0] exp_minor_cfg = 8'd0;

  // Our copy of the per-buffer state, at its reset values.
  logic [CountW-1:0] seen_count = '0;
  logic              magic_ok_m = 1'b1;
  logic [7:0]        major_m = '0;
  logic [7:0]        minor_m = '0;
  logic [31:0]       crc_m = CrcInit;
  logic [7:0]        tail_m[4] = '{default: 8'h00};

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Outside burst mode the result side stalls at random, about nine percent of the time. Its ready
  // changes on the falling edge so the block always sees a settled value.
  always @(negedge clk_i) begin
    out_ready_i <= burst_mode || ($urandom_range(99) >= 9);
  end

  // Reflected CRC-32 over one byte, LSB first.
  function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Advances our copy of the state by one accepted byte. On the final byte it
  // works out the verdict, queues it, and clears the state as the block does.
  task automatic predict_verdict(logic [7:0] b, logic last);
    verdict_t          v;
    logic [CountW-1:0] n;
    logic [31:0]       trailer;
    if (seen_count < 4) begin
      if (b != MagicWord[8*seen_count +: 8]) begin
        magic_ok_m = 1'b0;
      end
    end else if (seen_count == 4) begin
      major_m = b;
    end else if (seen_count == 5) begin
      minor_m = b;
    end
    // The CRC runs four bytes behind the input, so the trailer never enters it.
    if (seen_count >= 4) begin
      crc_m = crc32_step(crc_m, tail_m[0]);
    end
    for (int i = 0; i < 3; i++) begin
      tail_m[i] = tail_m[i+1];
    end
    tail_m[3] = b;
    if (seen_count < CountSat) begin
      seen_count++;
    end
    if (!last) begin
      return;
    end

    n = seen_count;
    trailer = {tail_m[3], tail_m[2], tail_m[1], tail_m[0]};
    v = '{status: StatusOk, sev: SevOk, warn: 1'b0, crc: ~crc_m};
    // The checks run in a fixed order and the first failing one decides.
    if (n < 4) begin
      v.status = StatusTruncated;
      v.sev = SevFatal;
    end else if (!magic_ok_m) begin
      v.status = StatusBadMagic;
      v.sev = SevFatal;
    end else if (n < 6) begin
      v.status = StatusTruncated;
      v.sev = SevFatal;
    end else if (strict_cfg && (major_m != exp_major_cfg || minor_m != exp_minor_cfg)) begin
      v.status = StatusBadVer;
      v.sev = SevError;
    end else begin
      // A newer major only warns, and the warning survives a later failure.
      if (!strict_cfg && major_m > exp_major_cfg) begin
        v.warn = 1'b1;
        v.sev = SevWarning;
      end
      if (n < 8) begin
        v.status = StatusTruncated;
        v.sev = SevFatal;
      end else if (crc_on_cfg && trailer != ~crc_m) begin
        v.status = StatusCrcFail;
        v.sev = SevError;
      end
    end
    verdict_q.push_back(v);

    seen_count = '0;
    magic_ok_m = 1'b1;
    major_m = '0;
    minor_m = '0;
    crc_m = CrcInit;
    tail_m = '{default: 8'h00};
  endtask

  // Each result transfer is checked against the oldest verdict still owed.
  always @(posedge clk_i) begin : check_results
    verdict_t got;
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status: status_e'(status_code_o), sev: severity_e'(severity_o),
              warn: version_warning_o, crc: computed_crc_o};
      if (verdict_q.size() == 0) begin
        if (fail_count < MaxReported) begin
          $display("unexpected result: status=%0d sev=%0d warn=%0b crc=%08h",
                   got.status, got.sev, got.warn, got.crc);
        end
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          if (fail_count < MaxReported) begin
            $display("verdict mismatch at cycle %0d", cycle_count);
            $display("  expected status=%0d sev=%0d warn=%0b crc=%08h",
                     want.status, want.sev, want.warn, want.crc);
            $display("  actual   status=%0d sev=%0d warn=%0b crc=%08h",
                     got.status, got.sev, got.warn, got.crc);
          end
          fail_count++;
        end
      end
    end
  end

  // Offers one byte and returns right after the edge at which it is taken.
  // The sender idles at random before the byte, except in burst mode. Valid is
  // left high, so the next byte of a frame can follow in the very next cycle.
  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk_i);
    while (!burst_mode && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_verdict(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // Drops valid once the last byte of a test has been taken.
  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic push_magic();
    for (int i = 0; i < 4; i++) begin
      frame_q.push_back(MagicWord[8*i +: 8]);
    end
  endtask

  // Appends the little-endian CRC-32 of everything already in the frame.
  task automatic append_crc_trailer();
    logic [31:0] c;
    c = CrcInit;
    foreach (frame_q[i]) begin
      c = crc32_step(c, frame_q[i]);
    end
    c = ~c;
    for (int i = 0; i < 4; i++) begin
      frame_q.push_back(c[8*i +: 8]);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Registers change only with no buffer in flight. Every buffer ends with a
  // final byte, so once all verdicts are in the block is idle.
  task automatic configure(logic crc_on, logic strict_on, logic [7:0] major,
                           logic [7:0] minor);
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(RegCrcEnable, CfgDataW'(crc_on));
    write_reg(RegStrictVer, CfgDataW'(strict_on));
    write_reg(RegExpMajor, major);
    write_reg(RegExpMinor, minor);
    crc_on_cfg = crc_on;
    strict_cfg = strict_on;
    exp_major_cfg = major;
    exp_minor_cfg = minor;
  endtask

  // Half the time the supported version, otherwise its neighbors, the extremes or a random value.
  function automatic logic [7:0] pick_version(logic [7:0] want);
    case ($urandom_range(9))
      0: return want + 8'd1;
      1: return want - 8'd1;
      2: return 8'h00;
      3: return 8'hFF;
      4: return 8'($urandom);
      default: return want;
    endcase
  endfunction

  // A complete buffer: magic, version, marker, payload and CRC trailer. Most
  // payloads are short, a few are long and run the count many bytes past
  // saturation. Some trailers get one bit flipped.
  task automatic build_wellformed_frame();
    int unsigned payload_len;
    int unsigned idx;
    frame_q.delete();
    push_magic();
    frame_q.push_back(pick_version(exp_major_cfg));
    frame_q.push_back(pick_version(exp_minor_cfg));
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    payload_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(8);
    repeat (payload_len) frame_q.push_back(8'($urandom));
    append_crc_trailer();
    if ($urandom_range(99) < 15) begin
      idx = frame_q.size() - 1 - $urandom_range(3);
      frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(7));
    end
  endtask

  // Streams random frames until about budget bytes have gone out. Seven in ten
  // are well formed; the rest are cut short, carry a damaged magic word, or
  // are plain noise.
  task automatic run_random_frames(int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned cut;
    int unsigned idx;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      build_wellformed_frame();
      if (pick >= 90) begin
        frame_q.delete();
        repeat ($urandom_range(1, 16)) frame_q.push_back(8'($urandom));
      end else if (pick >= 80) begin
        idx = $urandom_range(3);
        frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
      end else if (pick >= 70) begin
        // Cuts land on every truncation boundary: before the magic is
        // complete, before the version, before the eighth byte, and past it.
        cut = $urandom_range(1, 9);
        while (frame_q.size() > cut) frame_q.pop_back();
      end
      sent += frame_q.size();
      send_frame();
    end
    release_input();
  endtask

  // Short hand-built buffers under the reset configuration.
  task automatic test_directed_cases();
    // A lone final byte: nothing seen, the CRC of the empty string.
    frame_q = '{8'hFF};
    send_frame();
    // Too short even for the magic, which is wrong as well.
    frame_q = '{8'h00, 8'hFF, MagicWord[23:16]};
    send_frame();
    // Good magic and a major version, but no minor version.
    frame_q.delete();
    push_magic();
    frame_q.push_back(8'h01);
    send_frame();
    // Four bytes with the last magic byte wrong.
    frame_q = '{MagicWord[7:0], MagicWord[15:8], MagicWord[23:16], 8'hFF};
    send_frame();
    // The shortest complete buffer: the trailer overlaps the version bytes.
    frame_q.delete();
    push_magic();
    append_crc_trailer();
    send_frame();
    // A newer major than supported only warns and the buffer passes.
    frame_q.delete();
    push_magic();
    frame_q.push_back(8'h02);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    append_crc_trailer();
    send_frame();
    release_input();
  endtask

  task automatic test_default_settings();
    configure(1'b1, 1'b0, 8'd1, 8'd0);
    run_random_frames(250);
  endtask

  task automatic test_strict_version_at_max();
    configure(1'b1, 1'b1, 8'hFF, 8'hFF);
    run_random_frames(250);
  endtask

  task automatic test_crc_check_disabled();
    configure(1'b0, 1'b0, 8'h00, 8'h00);
    run_random_frames(250);
  endtask

  // Strict mode at the lowest version, with no idling on either side.
  task automatic test_back_to_back_strict();
    configure(1'b1, 1'b1, 8'h00, 8'h00);
    burst_mode = 1'b1;
    run_random_frames(250);
    burst_mode = 1'b0;
  endtask

  // Only a major of 255 is newer here, and the minor is arbitrary.
  task automatic test_newer_major_warning();
    configure(1'b1, 1'b0, 8'hFE, 8'($urandom));
    run_random_frames(250);
  endtask

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_default_settings();
    test_strict_version_at_max();
    test_crc_check_disabled();
    test_back_to_back_strict();
    test_newer_major_warning();

    // Wait for every owed verdict, then a little longer to catch strays.
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* format_header_and_crc_checker.f */
rtl/fhc_pkg.sv
rtl/fhc_crc_byte.sv
rtl/format_header_and_crc_checker.sv
tb/format_header_and_crc_checker_tb.sv
